[design/ffha_pkg.sv]
// ffha_pkg: constants, item types, tag layout and sequencer states for the
// first-fit heap allocator. No dependencies.
package ffha_pkg;

  localparam int HEAP_SIZE      = 4096;
  localparam int BLOCK_OVERHEAD = 40;
  localparam int HEADER_BYTES   = 32;
  localparam int FOOTER_BYTES   = BLOCK_OVERHEAD - HEADER_BYTES;

  localparam int ADDR_W = $clog2(HEAP_SIZE);    // heap offset
  localparam int LINK_W = ADDR_W + 1;           // link, size, byte total
  localparam int SUM_W  = LINK_W + 1;           // offset plus size
  localparam int CNT_W  = 7;

  localparam logic [LINK_W-1:0] LINK_BEGIN = LINK_W'(HEAP_SIZE);
  localparam logic [LINK_W-1:0] LINK_END   = LINK_W'(HEAP_SIZE + 1);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // list select
  localparam logic LIST_FREE = 1'b0;
  localparam logic LIST_USED = 1'b1;

  // per-offset tag kept in the tag memory
  typedef struct packed {
    logic              valid;
    logic              used;
    logic [LINK_W-1:0] size;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] next;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  typedef struct packed {
    logic              operation;
    logic [LINK_W-1:0] request_bytes;
    logic [ADDR_W-1:0] payload_offset;
    logic              pointer_is_null;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_offset;
    logic              result_is_null;
    logic [CNT_W-1:0]  free_block_count;
    logic [LINK_W-1:0] free_list_bytes;
    logic [CNT_W-1:0]  used_block_count;
    logic [LINK_W-1:0] used_list_bytes;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_INIT, ST_IDLE,
    ST_A_START, ST_A_WALK, ST_A_CHK, ST_A_SPLIT, ST_A_NB, ST_A_USED,
    ST_R_START, ST_R_CHK, ST_R_FREE,
    ST_M_RD, ST_M_CHK1, ST_M_CHK2, ST_M_RD_UP, ST_M_UP2, ST_M_JOIN, ST_M_END,
    ST_B_START, ST_B_CHK, ST_B_CHK2,
    ST_ADD_WR, ST_REM_A, ST_REM_B, ST_RMW_RD, ST_RMW_WR,
    ST_DONE
  } state_t;

endpackage

[design/ffha_req_if.sv]
// ffha_req_if: request channel (valid, ready, request item).
// Depends on ffha_pkg.
interface ffha_req_if import ffha_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/ffha_rsp_if.sv]
// ffha_rsp_if: result channel (valid, ready, result item).
// Depends on ffha_pkg.
interface ffha_rsp_if import ffha_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/ffha_ram.sv]
// ffha_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[design/first_fit_heap_allocator.sv]
// first_fit_heap_allocator: first-fit allocator over a tag memory and a footer
// memory. Depends on ffha_pkg, ffha_req_if, ffha_rsp_if, ffha_ram.
//
//  channel | dir | payload
//  req     | in  | operation, request_bytes, payload_offset, pointer_is_null
//  rsp     | out | result_offset, result_is_null, list counts and byte totals
//
// One item at a time. An allocate walks the free list up to twice, with one tag memory
// read per free block visited, then unlinks the chosen block, splits it when it is
// large enough and pushes the pieces onto the lists.
// A release that frees a block does its read-modify-write link updates through
// the single tag memory; an ignored one goes straight to its result.
// After reset a clearing pass over all HEAP_SIZE entries, then one init write,
// runs before the first item is taken.
// A stalled result holds in the output register; a finished item waits in its
// last state until that register frees.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp
);

  state_t state, state_next;
  state_t rmw_ret, list_ret;

  // item and working registers
  logic [LINK_W-1:0] op_n;
  logic [ADDR_W-1:0] op_off;
  logic              pass, second, rmw_prev_sel, lsel, x_used;
  logic [LINK_W-1:0] w;
  logic [ADDR_W-1:0] blk, nb, x_addr, rmw_addr, m_low, m_up, fo, clr;
  logic [LINK_W-1:0] blk_size, nb_size, x_size, rmw_val;
  logic [LINK_W-1:0] r_prev, r_next, r_size, m_low_size, m_up_size;
  logic [LINK_W-1:0] free_first, free_last, used_first, used_last;
  logic [CNT_W-1:0]  free_cnt, used_cnt;
  logic [LINK_W-1:0] free_tot, used_tot;
  logic              res_got;
  logic [ADDR_W-1:0] res_off;
  logic              out_valid;
  rsp_t              out_data;

  // memory ports
  logic              tag_we, tag_re, foot_we, foot_re;
  logic [ADDR_W-1:0] tag_waddr, tag_raddr, foot_waddr, foot_raddr;
  tag_t              tag_wdata, tag_rd;
  logic [TAG_W-1:0]  tag_rdata;
  logic [LINK_W-1:0] foot_wdata, foot_rdata;

  assign tag_rd = tag_t'(tag_rdata);

  ffha_ram #(.WIDTH(TAG_W), .DEPTH(HEAP_SIZE)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .re(tag_re), .raddr(tag_raddr), .rdata(tag_rdata)
  );

  ffha_ram #(.WIDTH(LINK_W), .DEPTH(HEAP_SIZE)) u_foot_ram (
    .clk(clk), .we(foot_we), .waddr(foot_waddr), .wdata(foot_wdata),
    .re(foot_re), .raddr(foot_raddr), .rdata(foot_rdata)
  );

  // shared conditions
  logic              accept, out_free, cur_first_end;
  logic [LINK_W-1:0] cur_first;
  logic [SUM_W-1:0]  need_split, need, nb_sum, up_sum, lo_sub;
  logic              a_fit, a_split, r_ok, m1_ok, m2_ok, b_ok, b_neg, b2_ok;
  logic [ADDR_W-1:0] p_blk, fo_calc, lo;
  logic [LINK_W-1:0] join_size;

  assign accept        = req.valid && req.ready;
  assign req.ready     = (state == ST_IDLE);
  assign out_free      = !out_valid || rsp.ready;
  assign cur_first     = (lsel == LIST_USED) ? used_first : free_first;
  assign cur_first_end = cur_first[ADDR_W];

  assign need_split = {1'b0, op_n} + SUM_W'(BLOCK_OVERHEAD + 1);
  assign need       = pass ? {1'b0, op_n} : need_split;
  assign a_fit      = {1'b0, tag_rd.size} >= need;
  assign a_split    = {1'b0, blk_size} >= need_split;
  assign nb_sum     = SUM_W'(blk) + SUM_W'(BLOCK_OVERHEAD) + {1'b0, op_n};
  assign p_blk      = op_off - ADDR_W'(HEADER_BYTES);
  assign r_ok       = tag_rd.valid && tag_rd.used;
  assign up_sum     = SUM_W'(m_low) + {1'b0, tag_rd.size} + SUM_W'(BLOCK_OVERHEAD);
  assign m1_ok      = tag_rd.valid && !tag_rd.used && (up_sum < SUM_W'(HEAP_SIZE));
  assign m2_ok      = tag_rd.valid && !tag_rd.used;
  assign join_size  = m_low_size + LINK_W'(BLOCK_OVERHEAD) + m_up_size;
  assign b_ok       = blk > ADDR_W'(FOOTER_BYTES);
  assign fo_calc    = blk - ADDR_W'(FOOTER_BYTES);
  assign lo_sub     = SUM_W'(HEADER_BYTES) + {1'b0, foot_rdata};
  assign b_neg      = SUM_W'(fo) < lo_sub;
  assign lo         = fo - lo_sub[ADDR_W-1:0];
  assign b2_ok      = tag_rd.valid && !tag_rd.used;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr == ADDR_W'(HEAP_SIZE - 1)) state_next = ST_INIT;
      ST_INIT:    state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (req.data.operation == OP_ALLOC) state_next = ST_A_START;
          else if (!req.data.pointer_is_null) state_next = ST_R_START;
          else state_next = ST_DONE;
        end
      end
      ST_A_START: state_next = (op_n == '0) ? ST_DONE : ST_A_WALK;
      ST_A_WALK: begin
        if (!w[ADDR_W]) state_next = ST_A_CHK;
        else if (pass) state_next = ST_DONE;
      end
      ST_A_CHK:   state_next = a_fit ? ST_REM_A : ST_A_WALK;
      ST_A_SPLIT: state_next = a_split ? ST_A_NB : ST_A_USED;
      ST_A_NB:    state_next = ST_ADD_WR;
      ST_A_USED:  state_next = ST_ADD_WR;
      ST_R_START: state_next = (op_off < ADDR_W'(HEADER_BYTES)) ? ST_DONE : ST_R_CHK;
      ST_R_CHK:   state_next = r_ok ? ST_REM_A : ST_DONE;
      ST_R_FREE:  state_next = ST_ADD_WR;
      ST_M_RD:    state_next = ST_M_CHK1;
      ST_M_CHK1:  state_next = m1_ok ? ST_M_CHK2 : ST_M_END;
      ST_M_CHK2:  state_next = m2_ok ? ST_REM_A : ST_M_END;
      ST_M_RD_UP: state_next = ST_M_UP2;
      ST_M_UP2:   state_next = ST_REM_A;
      ST_M_JOIN:  state_next = ST_ADD_WR;
      ST_M_END:   state_next = second ? ST_DONE : ST_B_START;
      ST_B_START: state_next = b_ok ? ST_B_CHK : ST_DONE;
      ST_B_CHK:   state_next = b_neg ? ST_DONE : ST_B_CHK2;
      ST_B_CHK2:  state_next = b2_ok ? ST_M_RD : ST_DONE;
      ST_ADD_WR:  state_next = cur_first_end ? list_ret : ST_RMW_RD;
      ST_REM_A:   state_next = r_prev[ADDR_W] ? ST_REM_B : ST_RMW_RD;
      ST_REM_B:   state_next = r_next[ADDR_W] ? list_ret : ST_RMW_RD;
      ST_RMW_RD:  state_next = ST_RMW_WR;
      ST_RMW_WR:  state_next = rmw_ret;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    logic              pf_en;
    logic [ADDR_W-1:0] pf_x;
    logic [LINK_W-1:0] pf_s;
    logic [SUM_W-1:0]  pf_f;
    tag_t              t;
    pf_en     = 1'b0;
    pf_x      = blk;
    pf_s      = blk_size;
    t         = tag_rd;
    tag_we    = 1'b0;
    tag_waddr = x_addr;
    tag_wdata = '0;
    tag_re    = 1'b0;
    tag_raddr = w[ADDR_W-1:0];
    foot_re   = 1'b0;
    foot_raddr = fo_calc;
    unique case (state)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr;
      end
      ST_INIT: begin
        tag_we    = 1'b1;
        tag_waddr = '0;
        tag_wdata = '{valid: 1'b1, used: 1'b0,
                      size: LINK_W'(HEAP_SIZE - BLOCK_OVERHEAD),
                      prev: LINK_BEGIN, next: LINK_END};
        pf_en = 1'b1;
        pf_x  = '0;
        pf_s  = LINK_W'(HEAP_SIZE - BLOCK_OVERHEAD);
      end
      ST_A_WALK:  tag_re = !w[ADDR_W];
      ST_A_SPLIT: begin
        pf_en = a_split;
        pf_s  = op_n;
      end
      ST_A_NB: begin
        pf_en = 1'b1;
        pf_x  = nb;
        pf_s  = nb_size;
      end
      ST_A_USED:  pf_en = 1'b1;
      ST_R_START: begin
        tag_re    = !(op_off < ADDR_W'(HEADER_BYTES));
        tag_raddr = p_blk;
      end
      ST_R_FREE:  pf_en = 1'b1;
      ST_M_RD: begin
        tag_re    = 1'b1;
        tag_raddr = m_low;
      end
      ST_M_CHK1: begin
        tag_re    = m1_ok;
        tag_raddr = up_sum[ADDR_W-1:0];
      end
      ST_M_RD_UP: begin
        tag_re    = 1'b1;
        tag_raddr = m_up;
      end
      ST_M_UP2: begin
        t.valid   = 1'b0;
        tag_we    = 1'b1;
        tag_waddr = m_up;
        tag_wdata = t;
      end
      ST_M_JOIN: begin
        pf_en = 1'b1;
        pf_x  = m_low;
        pf_s  = join_size;
      end
      ST_B_START: foot_re = b_ok;
      ST_B_CHK: begin
        tag_re    = !b_neg;
        tag_raddr = lo;
      end
      ST_ADD_WR: begin
        tag_we    = 1'b1;
        tag_waddr = x_addr;
        tag_wdata = '{valid: 1'b1, used: x_used, size: x_size,
                      prev: LINK_BEGIN, next: cur_first};
      end
      ST_RMW_RD: begin
        tag_re    = 1'b1;
        tag_raddr = rmw_addr;
      end
      ST_RMW_WR: begin
        if (rmw_prev_sel) t.prev = rmw_val;
        else t.next = rmw_val;
        tag_we    = 1'b1;
        tag_waddr = rmw_addr;
        tag_wdata = t;
      end
      default: ;
    endcase
    // footer write: size copy just past the payload, if inside the heap
    pf_f       = SUM_W'(pf_x) + SUM_W'(HEADER_BYTES) + {1'b0, pf_s};
    foot_we    = (state == ST_CLEAR) || (pf_en && (pf_f < SUM_W'(HEAP_SIZE)));
    foot_waddr = (state == ST_CLEAR) ? clr : pf_f[ADDR_W-1:0];
    foot_wdata = (state == ST_CLEAR) ? '0 : pf_s;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      out_valid  <= 1'b0;
      free_first <= '0;
      free_last  <= '0;
      used_first <= LINK_END;
      used_last  <= LINK_BEGIN;
      free_cnt   <= CNT_W'(1);
      free_tot   <= LINK_W'(HEAP_SIZE);
      used_cnt   <= '0;
      used_tot   <= '0;
    end else begin
      state <= state_next;
      // result register: load on finish, clear once taken
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: begin
          op_n    <= req.data.request_bytes;
          op_off  <= req.data.payload_offset;
          res_got <= 1'b0;
          res_off <= '0;
        end
        ST_A_START: begin
          pass <= 1'b0;
          w    <= free_first;
        end
        ST_A_WALK: begin
          if (w[ADDR_W] && !pass) begin
            pass <= 1'b1;
            w    <= free_first;
          end
        end
        ST_A_CHK: begin
          if (a_fit) begin
            blk      <= w[ADDR_W-1:0];
            blk_size <= tag_rd.size;
            r_prev   <= tag_rd.prev;
            r_next   <= tag_rd.next;
            r_size   <= tag_rd.size;
            lsel     <= LIST_FREE;
            list_ret <= ST_A_SPLIT;
          end else begin
            w <= tag_rd.next;
          end
        end
        ST_A_SPLIT: begin
          if (a_split) begin
            nb       <= nb_sum[ADDR_W-1:0];
            nb_size  <= blk_size - op_n - LINK_W'(BLOCK_OVERHEAD);
            blk_size <= op_n;
          end
        end
        ST_A_NB: begin
          x_addr   <= nb;
          x_size   <= nb_size;
          x_used   <= 1'b0;
          lsel     <= LIST_FREE;
          list_ret <= ST_A_USED;
        end
        ST_A_USED: begin
          x_addr   <= blk;
          x_size   <= blk_size;
          x_used   <= 1'b1;
          lsel     <= LIST_USED;
          list_ret <= ST_DONE;
          res_got  <= 1'b1;
          res_off  <= blk + ADDR_W'(HEADER_BYTES);
        end
        ST_R_START: blk <= p_blk;
        ST_R_CHK: begin
          r_prev   <= tag_rd.prev;
          r_next   <= tag_rd.next;
          r_size   <= tag_rd.size;
          blk_size <= tag_rd.size;
          lsel     <= LIST_USED;
          list_ret <= ST_R_FREE;
        end
        ST_R_FREE: begin
          x_addr   <= blk;
          x_size   <= blk_size;
          x_used   <= 1'b0;
          lsel     <= LIST_FREE;
          list_ret <= ST_M_RD;
          m_low    <= blk;
          second   <= 1'b0;
        end
        ST_M_CHK1: begin
          m_up       <= up_sum[ADDR_W-1:0];
          m_low_size <= tag_rd.size;
          r_prev     <= tag_rd.prev;
          r_next     <= tag_rd.next;
          r_size     <= tag_rd.size;
        end
        ST_M_CHK2: begin
          m_up_size <= tag_rd.size;
          lsel      <= LIST_FREE;
          list_ret  <= ST_M_RD_UP;
        end
        ST_M_UP2: begin
          r_prev   <= tag_rd.prev;
          r_next   <= tag_rd.next;
          r_size   <= tag_rd.size;
          lsel     <= LIST_FREE;
          list_ret <= ST_M_JOIN;
        end
        ST_M_JOIN: begin
          x_addr   <= m_low;
          x_size   <= join_size;
          x_used   <= 1'b0;
          lsel     <= LIST_FREE;
          list_ret <= ST_M_END;
        end
        ST_B_START: fo <= fo_calc;
        ST_B_CHK:   m_low <= lo;
        ST_B_CHK2:  second <= 1'b1;
        // push x at the front of the selected list
        ST_ADD_WR: begin
          if (lsel == LIST_USED) begin
            used_first <= LINK_W'(x_addr);
            used_cnt   <= used_cnt + 1'b1;
            used_tot   <= used_tot + x_size + LINK_W'(BLOCK_OVERHEAD);
            if (cur_first_end) used_last <= LINK_W'(x_addr);
          end else begin
            free_first <= LINK_W'(x_addr);
            free_cnt   <= free_cnt + 1'b1;
            free_tot   <= free_tot + x_size + LINK_W'(BLOCK_OVERHEAD);
            if (cur_first_end) free_last <= LINK_W'(x_addr);
          end
          rmw_addr     <= cur_first[ADDR_W-1:0];
          rmw_val      <= LINK_W'(x_addr);
          rmw_prev_sel <= 1'b1;
          rmw_ret      <= list_ret;
        end
        // unlink: predecessor side
        ST_REM_A: begin
          if (lsel == LIST_USED) begin
            used_cnt <= used_cnt - 1'b1;
            used_tot <= used_tot - r_size - LINK_W'(BLOCK_OVERHEAD);
            if (r_prev[ADDR_W]) used_first <= r_next;
          end else begin
            free_cnt <= free_cnt - 1'b1;
            free_tot <= free_tot - r_size - LINK_W'(BLOCK_OVERHEAD);
            if (r_prev[ADDR_W]) free_first <= r_next;
          end
          rmw_addr     <= r_prev[ADDR_W-1:0];
          rmw_val      <= r_next;
          rmw_prev_sel <= 1'b0;
          rmw_ret      <= ST_REM_B;
        end
        // unlink: successor side
        ST_REM_B: begin
          if (r_next[ADDR_W]) begin
            if (lsel == LIST_USED) used_last <= r_prev;
            else free_last <= r_prev;
          end
          rmw_addr     <= r_next[ADDR_W-1:0];
          rmw_val      <= r_prev;
          rmw_prev_sel <= 1'b1;
          rmw_ret      <= list_ret;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data  <= '{result_offset: res_got ? res_off : '0,
                           result_is_null: !res_got,
                           free_block_count: free_cnt,
                           free_list_bytes: free_tot,
                           used_block_count: used_cnt,
                           used_list_bytes: used_tot};
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

[design/ffha_checker.sv]
// ffha_checker: port-level checks on first_fit_heap_allocator, bound to it.
// Depends on ffha_pkg.
module ffha_checker import ffha_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // overhead-inclusive bytes are conserved across both lists
  a_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.free_list_bytes + out_data.used_list_bytes)
                  == LINK_W'(HEAP_SIZE))
    else $error("byte totals do not cover the heap");

  a_null: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_is_null |-> out_data.result_offset == '0)
    else $error("null result with nonzero offset");

  a_alloc: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.result_is_null |->
      out_data.used_block_count != '0 &&
      out_data.result_offset >= ADDR_W'(HEADER_BYTES))
    else $error("allocation without a used block");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
);
